FILE: hdl/sbq_pkg.sv
// Shared constants, codes, request/response structs and control structs for the blocked queue table.
package sbq_pkg;

  localparam int MAX_PROCS = 20;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int KEY_W     = 32;
  localparam int PID_W     = 5;
  localparam int STAMP_W   = 32;
  localparam int PROC_W    = IDX_W + STAMP_W;

  localparam logic [1:0] CMD_BLOCK   = 2'd0;
  localparam logic [1:0] CMD_UNBLOCK = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;
  localparam logic [1:0] CMD_PEEK    = 2'd3;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOFREE   = 2'd1;
  localparam logic [1:0] STS_NOTFOUND = 2'd2;
  localparam logic [1:0] STS_DUP      = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] sem_key;
    logic [PID_W-1:0] proc_id;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             has_proc;
    logic [PID_W-1:0] proc_out;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSCAN,
    ST_PLATCH,
    ST_PSCAN,
    ST_BWRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               clr;
    logic               eval_desc;
    logic               eval_proc;
    logic               remove_mode;
    logic [IDX_W-1:0]   idx;
    logic               desc_vld;
    logic [KEY_W-1:0]   key_rd;
    logic [KEY_W-1:0]   key_ref;
    logic               proc_blk;
    logic [IDX_W-1:0]   pdesc_rd;
    logic [IDX_W-1:0]   d_ref;
    logic [STAMP_W-1:0] stamp_rd;
    logic [STAMP_W-1:0] stamp_now;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             best_found;
    logic [IDX_W-1:0] best_idx;
    logic             others;
  } scan_res_t;

endpackage

FILE: hdl/sbq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sbq_scan_unit.sv
// Shared scan unit: key compare, free slot search and oldest-entry age compare, one entry a cycle.
module sbq_scan_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  sbq_pkg::scan_ctl_t ctl,
  output sbq_pkg::scan_res_t res
);

  sbq_pkg::scan_res_t             res_r;
  sbq_pkg::scan_res_t             res_nxt;
  logic [sbq_pkg::STAMP_W-1:0]    best_age_r;
  logic [sbq_pkg::STAMP_W-1:0]    best_age_nxt;
  logic [sbq_pkg::STAMP_W-1:0]    age;
  logic                           hit;

  // Age is the distance of the entry's stamp behind the running counter, modulo 2^32.
  assign age = ctl.stamp_now - ctl.stamp_rd;
  assign hit = ctl.proc_blk && (ctl.pdesc_rd == ctl.d_ref);

  always_comb begin
    res_nxt      = res_r;
    best_age_nxt = best_age_r;
    if (ctl.clr) begin
      res_nxt      = '0;
      best_age_nxt = '0;
    end else if (ctl.eval_desc) begin
      if (!res_r.found && ctl.desc_vld && (ctl.key_rd == ctl.key_ref)) begin
        res_nxt.found     = 1'b1;
        res_nxt.found_idx = ctl.idx;
      end
      if (!res_r.free_found && !ctl.desc_vld) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = ctl.idx;
      end
    end else if (ctl.eval_proc && hit) begin
      res_nxt.others = res_r.others | ctl.remove_mode | res_r.best_found;
      if (!res_r.best_found || (age > best_age_r)) begin
        res_nxt.best_found = 1'b1;
        res_nxt.best_idx   = ctl.idx;
        best_age_nxt       = age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= '0;
      best_age_r <= '0;
    end else begin
      res_r      <= res_nxt;
      best_age_r <= best_age_nxt;
    end
  end

  assign res = res_nxt;

endmodule

FILE: hdl/semaphore_blocked_queue_table.sv
// Top level: command sequencer, descriptor and process storage, and the result register.
// Requests settled at once go straight to the finish state; a missed key or a full table
// costs one descriptor scan, block a descriptor scan and a write, remove a process latch and a
// process scan, unblock and peek a descriptor scan and a process scan over all MAX_PROCS entries.
// One request is in work at a time; a new one is taken while the last result still waits.
// Synchronous active-low reset frees all descriptors, unblocks all processes, zeroes the stamp.
module semaphore_blocked_queue_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sbq_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output sbq_pkg::out_rsp_t out_rsp
);

  // Control state.
  sbq_pkg::state_t                 state_r, state_nxt;
  logic [sbq_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [sbq_pkg::MAX_PROCS-1:0]   desc_valid_r, desc_valid_nxt;
  logic [sbq_pkg::MAX_PROCS-1:0]   proc_blocked_r, proc_blocked_nxt;
  logic [sbq_pkg::STAMP_W-1:0]     stamp_r, stamp_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Payload registers for the request in work and the finished result.
  sbq_pkg::in_req_t                req_r, req_nxt;
  logic [sbq_pkg::IDX_W-1:0]       d_r, d_nxt;
  logic                            alloc_r, alloc_nxt;
  sbq_pkg::out_rsp_t               res_r, res_nxt;
  sbq_pkg::out_rsp_t               out_rsp_r, out_rsp_nxt;

  // Storage ports.
  logic                            dk_we;
  logic [sbq_pkg::IDX_W-1:0]       dk_raddr;
  logic [sbq_pkg::KEY_W-1:0]       dk_rdata;
  logic                            pr_we;
  logic [sbq_pkg::IDX_W-1:0]       pr_raddr;
  logic [sbq_pkg::PROC_W-1:0]      pr_rdata;

  sbq_pkg::scan_ctl_t              scan_ctl;
  sbq_pkg::scan_res_t              scan_res;

  logic                            accept;
  logic                            out_free;
  logic                            in_pid_ok;
  logic [sbq_pkg::IDX_W-1:0]       in_pid_idx;
  logic [sbq_pkg::IDX_W-1:0]       pid_idx_r;
  logic [sbq_pkg::IDX_W-1:0]       cnt_idx;
  logic [sbq_pkg::CNT_W-1:0]       cnt_m1;
  logic                            scan_last;

  assign in_stall   = (state_r != sbq_pkg::ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign in_pid_ok  = (32'(in_req.proc_id) < 32'(sbq_pkg::MAX_PROCS));
  assign in_pid_idx = sbq_pkg::IDX_W'(in_req.proc_id);
  assign pid_idx_r  = sbq_pkg::IDX_W'(req_r.proc_id);
  assign cnt_idx    = cnt_r[sbq_pkg::IDX_W-1:0];
  assign cnt_m1     = cnt_r - sbq_pkg::CNT_W'(1);
  assign scan_last  = (cnt_r == sbq_pkg::CNT_W'(sbq_pkg::MAX_PROCS));

  // Descriptor keys, read one entry a cycle during the descriptor scan.
  sbq_ram #(
    .WIDTH (sbq_pkg::KEY_W),
    .DEPTH (sbq_pkg::MAX_PROCS)
  ) u_desc_key_ram (
    .clk   (clk),
    .we    (dk_we),
    .waddr (d_r),
    .wdata (req_r.sem_key),
    .raddr (dk_raddr),
    .rdata (dk_rdata)
  );

  // Per-process descriptor index and insertion stamp, stored side by side.
  sbq_ram #(
    .WIDTH (sbq_pkg::PROC_W),
    .DEPTH (sbq_pkg::MAX_PROCS)
  ) u_proc_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pid_idx_r),
    .wdata ({d_r, stamp_r}),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  sbq_scan_unit u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .res   (scan_res)
  );

  // The scan unit sees the entry whose read was issued in the previous cycle, so the index it
  // evaluates trails the counter by one. Valid and blocked bits come straight from flops.
  always_comb begin
    scan_ctl             = '0;
    scan_ctl.idx         = cnt_m1[sbq_pkg::IDX_W-1:0];
    scan_ctl.desc_vld    = desc_valid_r[cnt_m1[sbq_pkg::IDX_W-1:0]];
    scan_ctl.key_rd      = dk_rdata;
    scan_ctl.key_ref     = req_r.sem_key;
    scan_ctl.proc_blk    = proc_blocked_r[cnt_m1[sbq_pkg::IDX_W-1:0]];
    scan_ctl.pdesc_rd    = pr_rdata[sbq_pkg::PROC_W-1 -: sbq_pkg::IDX_W];
    scan_ctl.d_ref       = d_r;
    scan_ctl.stamp_rd    = pr_rdata[sbq_pkg::STAMP_W-1:0];
    scan_ctl.stamp_now   = stamp_r;
    scan_ctl.remove_mode = (req_r.command == sbq_pkg::CMD_REMOVE);
    scan_ctl.clr         = accept;
    scan_ctl.eval_desc   = (state_r == sbq_pkg::ST_DSCAN) && (cnt_r != '0);
    scan_ctl.eval_proc   = (state_r == sbq_pkg::ST_PSCAN) && (cnt_r != '0);
  end

  // Sequencer: next state, storage updates and result staging.
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    desc_valid_nxt   = desc_valid_r;
    proc_blocked_nxt = proc_blocked_r;
    stamp_nxt        = stamp_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_rsp_nxt      = out_rsp_r;
    req_nxt          = req_r;
    d_nxt            = d_r;
    alloc_nxt        = alloc_r;
    res_nxt          = res_r;
    dk_we            = 1'b0;
    dk_raddr         = cnt_idx;
    pr_we            = 1'b0;
    pr_raddr         = cnt_idx;

    unique case (state_r)
      sbq_pkg::ST_IDLE: begin
        // The process entry of the incoming request is read ahead for a remove.
        pr_raddr = in_pid_idx;
        if (accept) begin
          req_nxt = in_req;
          cnt_nxt = '0;
          res_nxt = '{status: sbq_pkg::STS_OK, has_proc: 1'b0, proc_out: '0};
          unique case (in_req.command)
            sbq_pkg::CMD_BLOCK: begin
              if (in_req.sem_key == '0) begin
                state_nxt = sbq_pkg::ST_FINISH;
              end else if (!in_pid_ok) begin
                res_nxt.status = sbq_pkg::STS_NOTFOUND;
                state_nxt      = sbq_pkg::ST_FINISH;
              end else if (proc_blocked_r[in_pid_idx]) begin
                res_nxt.status = sbq_pkg::STS_DUP;
                state_nxt      = sbq_pkg::ST_FINISH;
              end else begin
                state_nxt = sbq_pkg::ST_DSCAN;
              end
            end
            sbq_pkg::CMD_REMOVE: begin
              if (!(in_pid_ok && proc_blocked_r[in_pid_idx])) begin
                res_nxt.status = sbq_pkg::STS_NOTFOUND;
                state_nxt      = sbq_pkg::ST_FINISH;
              end else begin
                state_nxt = sbq_pkg::ST_PLATCH;
              end
            end
            sbq_pkg::CMD_UNBLOCK, sbq_pkg::CMD_PEEK: begin
              if (in_req.sem_key == '0) begin
                res_nxt.status = sbq_pkg::STS_NOTFOUND;
                state_nxt      = sbq_pkg::ST_FINISH;
              end else begin
                state_nxt = sbq_pkg::ST_DSCAN;
              end
            end
          endcase
        end
      end

      sbq_pkg::ST_DSCAN: begin
        cnt_nxt = cnt_r + sbq_pkg::CNT_W'(1);
        if (scan_last) begin
          cnt_nxt = '0;
          if (req_r.command == sbq_pkg::CMD_BLOCK) begin
            if (scan_res.found) begin
              d_nxt     = scan_res.found_idx;
              alloc_nxt = 1'b0;
              state_nxt = sbq_pkg::ST_BWRITE;
            end else if (scan_res.free_found) begin
              d_nxt     = scan_res.free_idx;
              alloc_nxt = 1'b1;
              state_nxt = sbq_pkg::ST_BWRITE;
            end else begin
              res_nxt.status = sbq_pkg::STS_NOFREE;
              state_nxt      = sbq_pkg::ST_FINISH;
            end
          end else if (scan_res.found) begin
            d_nxt     = scan_res.found_idx;
            state_nxt = sbq_pkg::ST_PSCAN;
          end else begin
            res_nxt.status = sbq_pkg::STS_NOTFOUND;
            state_nxt      = sbq_pkg::ST_FINISH;
          end
        end
      end

      sbq_pkg::ST_PLATCH: begin
        // Descriptor of the process being removed; the process leaves its queue now.
        d_nxt                       = pr_rdata[sbq_pkg::PROC_W-1 -: sbq_pkg::IDX_W];
        proc_blocked_nxt[pid_idx_r] = 1'b0;
        cnt_nxt                     = '0;
        res_nxt.has_proc            = 1'b1;
        res_nxt.proc_out            = req_r.proc_id;
        state_nxt                   = sbq_pkg::ST_PSCAN;
      end

      sbq_pkg::ST_PSCAN: begin
        cnt_nxt = cnt_r + sbq_pkg::CNT_W'(1);
        if (scan_last) begin
          cnt_nxt   = '0;
          state_nxt = sbq_pkg::ST_FINISH;
          if (req_r.command == sbq_pkg::CMD_REMOVE) begin
            if (!scan_res.others) begin
              desc_valid_nxt[d_r] = 1'b0;
            end
          end else if (!scan_res.best_found) begin
            res_nxt.status = sbq_pkg::STS_NOTFOUND;
          end else begin
            res_nxt.has_proc = 1'b1;
            res_nxt.proc_out = sbq_pkg::PID_W'(scan_res.best_idx);
            if (req_r.command == sbq_pkg::CMD_UNBLOCK) begin
              proc_blocked_nxt[scan_res.best_idx] = 1'b0;
              if (!scan_res.others) begin
                desc_valid_nxt[d_r] = 1'b0;
              end
            end
          end
        end
      end

      sbq_pkg::ST_BWRITE: begin
        dk_we                       = alloc_r;
        pr_we                       = 1'b1;
        desc_valid_nxt[d_r]         = 1'b1;
        proc_blocked_nxt[pid_idx_r] = 1'b1;
        stamp_nxt                   = stamp_r + sbq_pkg::STAMP_W'(1);
        state_nxt                   = sbq_pkg::ST_FINISH;
      end

      sbq_pkg::ST_FINISH: begin
        if (out_free) begin
          out_rsp_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = sbq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sbq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sbq_pkg::ST_IDLE;
      cnt_r          <= '0;
      desc_valid_r   <= '0;
      proc_blocked_r <= '0;
      stamp_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      desc_valid_r   <= desc_valid_nxt;
      proc_blocked_r <= proc_blocked_nxt;
      stamp_r        <= stamp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    d_r       <= d_nxt;
    alloc_r   <= alloc_nxt;
    res_r     <= res_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
